/* rtl/pfn_pkg.sv */
// Shared types, constants and gradient helpers for the fractal noise block.
`timescale 1ns / 1ps
package pfn_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [3:0]  OCT_RESET  = 4'd4;
  localparam logic [15:0] GAIN_RESET = 16'd2048;
  localparam logic [15:0] LAC_RESET  = 16'd8192;
  localparam logic [23:0] BASE_RESET = 24'd65536;
  localparam logic [15:0] AMP_INIT   = 16'd4096;

  localparam logic signed [24:0] ONE_Q15    = 25'sd32768;
  localparam logic signed [24:0] DIAG_Q15   = 25'sd23170;
  localparam logic signed [16:0] ONE_Q16    = 17'sd65536;
  localparam logic signed [24:0] FIFTEEN_Q16 = 25'sd983040;
  localparam logic signed [24:0] TEN_Q16    = 25'sd655360;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OCTAVES = 8'd0,
    REG_GAIN    = 8'd1,
    REG_LAC     = 8'd2,
    REG_BASE    = 8'd3
  } reg_idx_t;

  // Signed sum of the offset components that the gradient code selects.
  function automatic logic signed [18:0] grad_sum(input logic [2:0] g,
                                                  input logic signed [16:0] dx,
                                                  input logic signed [16:0] dy);
    logic signed [18:0] ex;
    logic signed [18:0] ey;
    logic signed [18:0] s;
    ex = 19'(dx);
    ey = 19'(dy);
    case (g)
      3'd0:    s = ex;
      3'd1:    s = -ex;
      3'd2:    s = ey;
      3'd3:    s = -ey;
      3'd4:    s = ex + ey;
      3'd5:    s = ey - ex;
      3'd6:    s = ex - ey;
      default: s = -ex - ey;
    endcase
    return s;
  endfunction

  function automatic logic signed [24:0] grad_coef(input logic [2:0] g);
    return g[2] ? DIAG_Q15 : ONE_Q15;
  endfunction

endpackage

/* rtl/pfn_chan_if.sv */
// Channel interfaces: sample input, noise result and configuration write.
`timescale 1ns / 1ps
interface pfn_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [8:0]  table_index;
  logic [7:0]  table_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  modport source (output valid, op, table_index, table_value, x_coord, y_coord,
                  input ready);
  modport sink (input valid, op, table_index, table_value, x_coord, y_coord,
                output ready);
endinterface

interface pfn_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

interface pfn_cfg_if;
  import pfn_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pfn_div.sv */
// Restoring divider, one quotient bit per cycle, sign and magnitude result.
`timescale 1ns / 1ps
module pfn_div #(
  parameter int NW = 42,
  parameter int DW = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] dividend,
  input  logic [DW-1:0]        divisor,
  output logic                 done,
  output logic                 neg,
  output logic [NW-1:0]        quot_mag
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dv_r;
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem_r, q_r[NW-1]};
    ge     = rem_sh >= {1'b0, dv_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend[NW-1] ? (~dividend + 1'b1) : dividend;
      neg_r <= dividend[NW-1];
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(rem_sh - {1'b0, dv_r}) : rem_sh[DW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign neg      = neg_r;
  assign quot_mag = q_r;
endmodule

/* rtl/perlin_fbm_noise_2d_top.sv */
// Fractal 2D gradient noise: table memory, octave sequencer, shared multiplier.
// Table write: taken while idle; the next item can be taken the cycle after.
// Evaluation of n octaves (n capped at MAX_OCTAVES): each octave runs through its steps on the
//   shared 33x25 multiplier, one table read per cycle, then the bit-serial divider runs and the
//   output register is loaded; the next item is taken once the result sits in that register,
//   which holds while out_ch.ready is low.
// Reset: registers take their reset values, the table is undefined until written.
`timescale 1ns / 1ps
module perlin_fbm_noise_2d_top #(
  parameter int TABLE_WORDS = 512,
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  pfn_cfg_if.sink     cfg_ch,
  pfn_in_if.sink      in_ch,
  pfn_out_if.source   out_ch
);
  import pfn_pkg::*;

  localparam int AW = $clog2(TABLE_WORDS);
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int SW = 16 + OW;
  localparam int NW = 38 + OW;
  localparam int DW = SW + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    K_MX, K_MY, K_FX0, K_FX1, K_FX2, K_FX3, K_FX4,
    K_FY0, K_FY1, K_FY2, K_FY3, K_FY4,
    K_C00, K_C10, K_C01, K_C11,
    K_L0, K_L1, K_L2, K_L3, K_NZ, K_AM, K_AC, K_GA, K_FQ
  } step_t;

  state_t state_r;
  step_t  step_r;

  logic [3:0]  oct_cnt_r;
  logic [15:0] gain_r;
  logic [15:0] lac_r;
  logic [23:0] base_r;

  logic [7:0] perm_mem [TABLE_WORDS];
  logic [7:0] rd_r;
  logic [AW-1:0] rd_addr;

  logic signed [31:0] x_r, y_r;
  logic [23:0] freq_r;
  logic [15:0] amp_r;
  logic signed [NW-1:0] acc_r;
  logic [SW-1:0] asum_r;
  logic [OW-1:0] oct_r, olim_r, olim;

  logic [15:0] fx_r, fy_r;
  logic [7:0]  cx_r, cy_r, hx0_r, hx1_r;
  logic [2:0]  g00_r, g10_r, g01_r, g11_r;
  logic signed [24:0] tb_r, c_r;
  logic [16:0] t2_r, u_r, v_r;
  logic signed [19:0] n00_r, n10_r, n01_r, n11_r;
  logic signed [20:0] nx0_r, nx1_r;
  logic signed [21:0] nz_r;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] p_r, p_sh16, p_sh15;
  logic [15:0] t_cur;
  logic signed [24:0] fade_a;
  logic [16:0] clamp_u;
  logic signed [16:0] fxs, fys, fxm, fym;

  logic        div_start, div_done, div_neg;
  logic [NW-1:0] div_mag;
  logic signed [15:0] res_r;
  logic signed [15:0] res_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic signed [15:0] out_data_r;

  logic in_xfer, cfg_xfer;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign cfg_xfer      = cfg_ch.valid && cfg_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.noise_value = out_data_r;

  assign out_valid_nxt = (state_r == S_FIN) || (out_valid_r && !out_ch.ready);

  always_comb begin
    if (int'(oct_cnt_r) > MAX_OCTAVES) olim = OW'(MAX_OCTAVES);
    else olim = OW'(oct_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= OCT_RESET;
      gain_r    <= GAIN_RESET;
      lac_r     <= LAC_RESET;
      base_r    <= BASE_RESET;
    end else if (cfg_xfer) begin
      case (cfg_ch.index)
        REG_OCTAVES: oct_cnt_r <= cfg_ch.data[3:0];
        REG_GAIN:    gain_r    <= cfg_ch.data[15:0];
        REG_LAC:     lac_r     <= cfg_ch.data[15:0];
        REG_BASE:    base_r    <= cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

  assign p_sh16 = p_r >>> 16;
  assign p_sh15 = p_r >>> 15;
  assign fxs = $signed({1'b0, fx_r});
  assign fys = $signed({1'b0, fy_r});
  assign fxm = fxs - ONE_Q16;
  assign fym = fys - ONE_Q16;

  always_comb begin
    if (p_sh16[57]) clamp_u = '0;
    else if (p_sh16 > 58'sd65536) clamp_u = 17'd65536;
    else clamp_u = p_sh16[16:0];
  end

  always_comb begin
    t_cur  = (step_r == K_FX0) ? fx_r : fy_r;
    fade_a = $signed({9'b0, t_cur}) * 25'sd6 - FIFTEEN_Q16;
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = AW'(cx_r);
    case (step_r)
      K_MX: begin mul_a = 33'(x_r); mul_b = $signed({1'b0, freq_r}); end
      K_MY: begin mul_a = 33'(y_r); mul_b = $signed({1'b0, freq_r}); end
      K_FX0: begin
        rd_addr = AW'(cx_r);
        mul_a = $signed({17'b0, fx_r}); mul_b = fade_a;
      end
      K_FX1: begin
        rd_addr = AW'(cx_r) + AW'(1);
        mul_a = $signed({17'b0, fx_r}); mul_b = $signed({9'b0, fx_r});
      end
      K_FX2: begin
        rd_addr = AW'(hx0_r) + AW'(cy_r);
        mul_a = $signed({17'b0, fx_r}); mul_b = tb_r;
      end
      K_FX3: begin
        rd_addr = AW'(hx1_r) + AW'(cy_r);
        mul_a = $signed({16'b0, t2_r}); mul_b = $signed({9'b0, fx_r});
      end
      K_FX4: begin
        rd_addr = AW'(hx0_r) + AW'(cy_r) + AW'(1);
        mul_a = p_sh16[32:0]; mul_b = c_r;
      end
      K_FY0: begin
        rd_addr = AW'(hx1_r) + AW'(cy_r) + AW'(1);
        mul_a = $signed({17'b0, fy_r}); mul_b = fade_a;
      end
      K_FY1: begin mul_a = $signed({17'b0, fy_r}); mul_b = $signed({9'b0, fy_r}); end
      K_FY2: begin mul_a = $signed({17'b0, fy_r}); mul_b = tb_r; end
      K_FY3: begin mul_a = $signed({16'b0, t2_r}); mul_b = $signed({9'b0, fy_r}); end
      K_FY4: begin mul_a = p_sh16[32:0]; mul_b = c_r; end
      K_C00: begin mul_a = 33'(grad_sum(g00_r, fxs, fys)); mul_b = grad_coef(g00_r); end
      K_C10: begin mul_a = 33'(grad_sum(g10_r, fxm, fys)); mul_b = grad_coef(g10_r); end
      K_C01: begin mul_a = 33'(grad_sum(g01_r, fxs, fym)); mul_b = grad_coef(g01_r); end
      K_C11: begin mul_a = 33'(grad_sum(g11_r, fxm, fym)); mul_b = grad_coef(g11_r); end
      K_L0: begin mul_a = $signed({16'b0, u_r}); mul_b = 25'(n10_r) - 25'(n00_r); end
      K_L1: begin mul_a = $signed({16'b0, u_r}); mul_b = 25'(n11_r) - 25'(n01_r); end
      K_L3: begin mul_a = $signed({16'b0, v_r}); mul_b = 25'(nx1_r) - 25'(nx0_r); end
      K_AM: begin mul_a = 33'(nz_r); mul_b = $signed({9'b0, amp_r}); end
      K_AC: begin mul_a = $signed({17'b0, amp_r}); mul_b = $signed({9'b0, gain_r}); end
      K_GA: begin mul_a = $signed({9'b0, freq_r}); mul_b = $signed({9'b0, lac_r}); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.op == OP_WRITE) perm_mem[in_ch.table_index[AW-1:0]] <= in_ch.table_value;
    rd_r <= perm_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= K_MX;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_xfer && in_ch.op == OP_EVAL) begin
            step_r  <= K_MX;
            state_r <= (olim == '0) ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          if (step_r == K_FQ) begin
            step_r  <= K_MX;
            state_r <= (oct_r + 1'b1 == olim_r) ? S_DIV : S_RUN;
          end else begin
            step_r <= step_t'(step_r + 1'b1);
          end
        end
        S_DIV: begin
          if (div_done) state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign div_start = (state_r == S_RUN) && (step_r == K_FQ) && (oct_r + 1'b1 == olim_r);

  always_comb begin
    if (!div_neg) res_nxt = (div_mag > NW'(32767)) ? 16'sh7FFF : $signed(div_mag[15:0]);
    else res_nxt = (div_mag > NW'(32768)) ? 16'sh8000 : $signed(~div_mag[15:0] + 16'd1);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) out_data_r <= res_r;
    if (state_r == S_DIV && div_done) res_r <= res_nxt;
    if (state_r == S_IDLE && in_xfer) begin
      x_r    <= in_ch.x_coord;
      y_r    <= in_ch.y_coord;
      freq_r <= base_r;
      amp_r  <= AMP_INIT;
      acc_r  <= '0;
      asum_r <= '0;
      oct_r  <= '0;
      olim_r <= olim;
      res_r  <= '0;
    end
    if (state_r == S_RUN) begin
      case (step_r)
        K_MY:  begin fx_r <= p_r[31:16]; cx_r <= p_r[39:32]; end
        K_FX0: begin fy_r <= p_r[31:16]; cy_r <= p_r[39:32]; end
        K_FX1: begin hx0_r <= rd_r; tb_r <= p_sh16[24:0] + TEN_Q16; end
        K_FX2: begin hx1_r <= rd_r; t2_r <= p_sh16[16:0]; end
        K_FX3: begin g00_r <= rd_r[2:0]; c_r <= p_sh16[24:0]; end
        K_FX4: g10_r <= rd_r[2:0];
        K_FY0: begin g01_r <= rd_r[2:0]; u_r <= clamp_u; end
        K_FY1: begin g11_r <= rd_r[2:0]; tb_r <= p_sh16[24:0] + TEN_Q16; end
        K_FY2: t2_r <= p_sh16[16:0];
        K_FY3: c_r <= p_sh16[24:0];
        K_C00: v_r <= clamp_u;
        K_C10: n00_r <= p_sh15[19:0];
        K_C01: n10_r <= p_sh15[19:0];
        K_C11: n01_r <= p_sh15[19:0];
        K_L0:  n11_r <= p_sh15[19:0];
        K_L1:  nx0_r <= 21'(n00_r) + p_sh16[20:0];
        K_L2:  nx1_r <= 21'(n01_r) + p_sh16[20:0];
        K_NZ:  nz_r <= 22'(nx0_r) + p_sh16[21:0];
        K_AC: begin
          acc_r  <= acc_r + NW'(p_r);
          asum_r <= asum_r + SW'(amp_r);
        end
        K_GA: amp_r <= (|p_r[57:28]) ? 16'hFFFF : p_r[27:12];
        K_FQ: begin
          freq_r <= (|p_r[57:36]) ? 24'hFFFFFF : p_r[35:12];
          oct_r  <= oct_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  pfn_div #(.NW(NW), .DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  ({asum_r, 1'b0}),
    .done     (div_done),
    .neg      (div_neg),
    .quot_mag (div_mag)
  );
endmodule
